// File: rtl/core/imaenc_pkg.sv
package imaenc_pkg;

  // default number of channels with their own predictor state
  localparam int unsigned MaxChannelsDef = 8;

  // step index range and predictor clamp limits
  localparam logic [6:0]         StepTop = 7'd88;
  localparam logic signed [15:0] PredMax = 16'sh7FFF;
  localparam logic signed [15:0] PredMin = 16'sh8000;

  // quantizer step sizes, indexed by step position
  localparam logic [14:0] StepTable [0:88] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  // input word: one pcm sample
  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic [2:0]         channel;
    logic               last_sample;
  } imaenc_in_t;

  // output word: one packed byte of two codes, or one padded code at stream end
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       end_of_stream;
  } imaenc_out_t;

  // per-channel predictor state
  typedef struct packed {
    logic signed [15:0] clamped_predictor;
    logic signed [17:0] raw_reconstruction;
    logic [6:0]         step_position;
  } chan_state_t;

endpackage

// File: rtl/core/imaenc_ram.sv
module imaenc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/imaenc_core.sv
module imaenc_core import imaenc_pkg::*; (
  input  logic signed [15:0] sample_i,
  input  chan_state_t        state_i,
  output logic [3:0]         code_o,
  output chan_state_t        state_o
);

  logic [6:0]         pos;
  logic [14:0]        step;
  logic signed [18:0] delta;
  logic [18:0]        mag;
  logic [18:0]        st0, st1, st2;
  logic [18:0]        rem1, rem2;
  logic               neg, c2, c1, c0;
  logic [16:0]        diff;
  logic signed [17:0] diff_s;
  logic signed [17:0] acc;
  logic signed [7:0]  move;
  logic signed [7:0]  pos_n;
  logic [6:0]         pos_upd;

  // step lookup with the index held in range
  always_comb begin
    pos  = (state_i.step_position > StepTop) ? StepTop : state_i.step_position;
    step = StepTable[pos];
  end

  // three-bit magnitude search against the unclamped reconstruction
  always_comb begin
    delta = 19'(sample_i) - 19'(state_i.raw_reconstruction);
    neg   = delta[18];
    mag   = neg ? 19'(-delta) : 19'(delta);
    st0   = {4'b0, step};
    st1   = st0 >> 1;
    st2   = st0 >> 2;
    c2    = mag > st0;
    rem1  = c2 ? (mag - st0) : mag;
    c1    = rem1 > st1;
    rem2  = c1 ? (rem1 - st1) : rem1;
    c0    = rem2 > st2;
    diff  = 17'(step >> 3) + (c2 ? 17'(st0) : 17'd0)
          + (c1 ? 17'(st1) : 17'd0) + (c0 ? 17'(st2) : 17'd0);
    code_o = {neg, c2, c1, c0};
  end

  // predictor update, only the clamped copy saturates
  always_comb begin
    diff_s = signed'({1'b0, diff});
    acc    = neg ? (18'(state_i.clamped_predictor) - diff_s)
                 : (18'(state_i.clamped_predictor) + diff_s);
    state_o.raw_reconstruction = acc;
    state_o.step_position      = pos_upd;
    if (neg && (acc < 18'(PredMin))) begin
      state_o.clamped_predictor = PredMin;
    end else if (!neg && (acc > 18'(PredMax))) begin
      state_o.clamped_predictor = PredMax;
    end else begin
      state_o.clamped_predictor = acc[15:0];
    end
  end

  // step index adaptation
  always_comb begin
    move  = c2 ? signed'(8'({c1, c0, 1'b0}) + 8'd2) : -8'sd1;
    pos_n = signed'({1'b0, pos}) + move;
    if (pos_n < 8'sd0) begin
      pos_upd = 7'd0;
    end else if (pos_n > signed'({1'b0, StepTop})) begin
      pos_upd = StepTop;
    end else begin
      pos_upd = pos_n[6:0];
    end
  end

endmodule

// File: rtl/core/ima_adpcm_encoder_packer.sv
// IMA ADPCM encoder with nibble packer, one sample word per clock if unstalled.
// A packed byte is registered when its completing word leaves the work stage.
// Throughput: one word per cycle if unstalled; the channel state RAM read plus
// a write-back bypass covers back-to-back samples of the same channel.
// Reset: predictor state reads as zero via per-channel valid bits, nibble
// packer and all handshake state cleared; no clearing pass.
module ima_adpcm_encoder_packer import imaenc_pkg::*; #(
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  imaenc_in_t  in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output imaenc_out_t out_word_o
);

  localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned StW = $bits(chan_state_t);

  logic              in_accept;
  logic              in_range;
  logic [ChW-1:0]    in_ch;
  logic              s1_valid_q, s1_valid_d;
  imaenc_in_t        s1_word_q;
  logic [ChW-1:0]    s1_ch_q;
  logic              s1_adv;
  logic [StW-1:0]    ram_rdata;
  chan_state_t       cur_state;
  chan_state_t       new_state;
  logic [3:0]        code;
  logic [MAX_CHANNELS-1:0] ch_valid_q;
  logic              wb_valid_q;
  logic [ChW-1:0]    wb_ch_q;
  chan_state_t       wb_state_q;
  logic [3:0]        held_q, held_d;
  logic              odd_q, odd_d;
  logic              res_valid;
  imaenc_out_t       res_word;
  logic              out_valid_q, out_valid_d;
  imaenc_out_t       out_word_q;

  // input handshake, out-of-range channels are taken and dropped
  assign in_ch      = ChW'(in_word_i.channel);
  assign in_range   = 32'(in_word_i.channel) < MAX_CHANNELS;
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = in_range;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q <= in_word_i;
      s1_ch_q   <= in_ch;
    end
  end

  // channel state store
  imaenc_ram #(
    .Width (StW),
    .Depth (MAX_CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_ch_q),
    .wdata_i (new_state),
    .re_i    (in_accept),
    .raddr_i (in_ch),
    .rdata_o (ram_rdata)
  );

  // state select: last write-back, then stored entry, then reset value
  always_comb begin
    if (wb_valid_q && (wb_ch_q == s1_ch_q)) begin
      cur_state = wb_state_q;
    end else if (ch_valid_q[s1_ch_q]) begin
      cur_state = chan_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  imaenc_core u_core (
    .sample_i (s1_word_q.pcm_sample),
    .state_i  (cur_state),
    .code_o   (code),
    .state_o  (new_state)
  );

  // valid bits and write-back bypass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_valid_q <= '0;
      wb_valid_q <= 1'b0;
    end else if (s1_adv) begin
      ch_valid_q[s1_ch_q] <= 1'b1;
      wb_valid_q          <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wb_ch_q    <= s1_ch_q;
      wb_state_q <= new_state;
    end
  end

  // nibble packer
  always_comb begin
    held_d    = held_q;
    odd_d     = odd_q;
    res_valid = 1'b0;
    res_word  = '0;
    if (odd_q) begin
      res_valid              = 1'b1;
      res_word.packed_byte   = {held_q, code};
      res_word.end_of_stream = s1_word_q.last_sample;
      held_d                 = 4'd0;
      odd_d                  = 1'b0;
    end else if (s1_word_q.last_sample) begin
      res_valid              = 1'b1;
      res_word.packed_byte   = {code, 4'd0};
      res_word.end_of_stream = 1'b1;
      held_d                 = 4'd0;
      odd_d                  = 1'b0;
    end else begin
      held_d = code;
      odd_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 4'd0;
      odd_q  <= 1'b0;
    end else if (s1_adv) begin
      held_q <= held_d;
      odd_q  <= odd_d;
    end
  end

  // result register
  assign out_valid_d = s1_adv ? res_valid : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) begin
      out_word_q <= res_word;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

`ifndef ASSERT_OFF
  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty work stage");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (new_state.step_position <= StepTop))
    else $error("step position out of range");

  a_last_clears_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_word_q.last_sample) |=> !odd_q)
    else $error("packer phase not cleared at end of stream");

  a_first_nibble_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !odd_q && !s1_word_q.last_sample) |=> !out_valid_o)
    else $error("byte produced from a single nibble");

  a_pair_gives_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && odd_q) |=> (out_valid_o && !odd_q))
    else $error("completed pair did not produce a byte");
`endif

endmodule
